// ===== src/picf_pkg.sv =====
package picf_pkg;

	localparam int DEF_MAX_REACH       = 16;
	localparam int DEF_COORD_FRAC_BITS = 16;

	localparam int          REACH_W     = 5;
	localparam logic [4:0]  REACH_RESET = 5'd16;

	localparam int FORCE_W   = 32;
	// quotient bits kept by the divider; anything at or above 2^QUOT_BITS saturates
	localparam int QUOT_BITS = 33;

	typedef struct packed {
		logic first;
		logic last;
		logic null_term;
	} term_tag_t;

endpackage

// ===== src/periodic_image_coulomb_force.sv =====
// Periodic image Coulomb field sum over a (2K+1) x (2K+1) lattice of images.
//
// Input channel (in_valid / in_stall): one displacement dx, dy, dz (Q3.16)
// and func per request; func = 1 drops the centre image. A request is taken
// when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): one result per request, fx, fy, fz
// in Q15.16 with saturation and an overflow flag.
// Config channel (cfg_valid / cfg_ready): writes image_reach (K); values above
// MAX_REACH act as MAX_REACH. cfg_ready is always high. Write only when idle.
//
// A sequencer sends one image per cycle into the term pipeline while out_stall
// does not hold it; in_stall stays high until the last image of a request is
// sent, so a new request is taken only after the previous one's images are out.
// On the way to the result the images pass the root chain and the divider (one
// bit per stage each), and the accumulator sums them.
// Reset clears all valid bits and sets image_reach to 16.
// While a result waits with out_stall high, the whole pipeline holds in place
// and in_stall is raised; nothing is lost or repeated.
module periodic_image_coulomb_force import picf_pkg::*; #(
	parameter int MAX_REACH       = DEF_MAX_REACH,
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [REACH_W-1:0]                   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_FRAC_BITS+3:0]    dx,
	input  logic signed [COORD_FRAC_BITS+3:0]    dy,
	input  logic signed [COORD_FRAC_BITS+3:0]    dz,
	input  logic                                 func,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [FORCE_W-1:0]            fx,
	output logic signed [FORCE_W-1:0]            fy,
	output logic signed [FORCE_W-1:0]            fz,
	output logic                                 overflow
);

	localparam int CW   = COORD_FRAC_BITS + 4;
	localparam int KW   = $clog2(MAX_REACH + 1);
	localparam int RW   = KW + 1;
	localparam int XW   = CW + KW;
	localparam int CMPW = (KW > REACH_W) ? KW : REACH_W;
	localparam int AW   = FORCE_W + $clog2((2 * MAX_REACH + 1) * (2 * MAX_REACH + 1)) + 1;
	localparam logic [CMPW-1:0] MAXK = CMPW'(MAX_REACH);

	logic en;
	logic in_acc;

	assign en       = !(out_valid && out_stall);
	assign cfg_ready = 1'b1;

	logic [REACH_W-1:0] image_reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_reach_q <= REACH_RESET;
		end else if (cfg_valid) begin
			image_reach_q <= cfg_data;
		end
	end

	// image sequencer
	logic                 busy_q;
	logic                 func_q;
	logic [KW-1:0]        k_q;
	logic signed [RW-1:0] i_q;
	logic signed [RW-1:0] j_q;
	logic signed [CW-1:0] x0_q;
	logic signed [CW-1:0] y0_q;
	logic signed [CW-1:0] z_q;
	logic [KW-1:0]        k_new;
	logic signed [RW-1:0] kpos;
	logic signed [RW-1:0] kneg;
	logic                 i_end;
	logic                 j_end;

	assign in_stall = busy_q || !en;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		if (CMPW'(image_reach_q) > MAXK) begin
			k_new = KW'(MAX_REACH);
		end else begin
			k_new = KW'(image_reach_q);
		end
	end

	assign kpos  = $signed({1'b0, k_q});
	assign kneg  = -kpos;
	assign i_end = (i_q == kpos);
	assign j_end = (j_q == kpos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (busy_q && en && i_end && j_end) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x0_q   <= dx;
			y0_q   <= dy;
			z_q    <= dz;
			func_q <= func;
			k_q    <= k_new;
			i_q    <= -$signed({1'b0, k_new});
			j_q    <= -$signed({1'b0, k_new});
		end else if (busy_q && en) begin
			if (i_end) begin
				i_q <= kneg;
				j_q <= j_q + RW'(1);
			end else begin
				i_q <= i_q + RW'(1);
			end
		end
	end

	term_tag_t            tag;
	logic signed [XW-1:0] img_x;
	logic signed [XW-1:0] img_y;
	logic signed [XW-1:0] img_z;

	assign tag.first     = (i_q == kneg) && (j_q == kneg);
	assign tag.last      = i_end && j_end;
	assign tag.null_term = func_q && (i_q == '0) && (j_q == '0);
	assign img_x = XW'(x0_q) + (XW'(i_q) <<< COORD_FRAC_BITS);
	assign img_y = XW'(y0_q) + (XW'(j_q) <<< COORD_FRAC_BITS);
	assign img_z = XW'(z_q);

	logic                      t_valid;
	term_tag_t                 t_tag;
	logic signed [FORCE_W-1:0] t_fx;
	logic signed [FORCE_W-1:0] t_fy;
	logic signed [FORCE_W-1:0] t_fz;
	logic                      t_ovf;

	picf_term #(
		.MAX_REACH      (MAX_REACH),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_term (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (busy_q),
		.in_tag   (tag),
		.in_x     (img_x),
		.in_y     (img_y),
		.in_z     (img_z),
		.out_valid(t_valid),
		.out_tag  (t_tag),
		.out_fx   (t_fx),
		.out_fy   (t_fy),
		.out_fz   (t_fz),
		.out_ovf  (t_ovf)
	);

	// accumulate per request, saturate on the last image
	logic signed [AW-1:0] ax_q;
	logic signed [AW-1:0] ay_q;
	logic signed [AW-1:0] az_q;
	logic                 aovf_q;
	logic signed [AW-1:0] sx;
	logic signed [AW-1:0] sy;
	logic signed [AW-1:0] sz;
	logic                 sovf;

	localparam logic signed [AW-1:0] SMAX = AW'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [AW-1:0] SMIN = AW'(-64'sh0000_0000_8000_0000);

	always_comb begin
		if (t_tag.first) begin
			sx   = AW'(t_fx);
			sy   = AW'(t_fy);
			sz   = AW'(t_fz);
			sovf = t_ovf;
		end else begin
			sx   = ax_q + AW'(t_fx);
			sy   = ay_q + AW'(t_fy);
			sz   = az_q + AW'(t_fz);
			sovf = aovf_q || t_ovf;
		end
	end

	function automatic logic signed [FORCE_W-1:0] clamp(input logic signed [AW-1:0] v);
		if (v > SMAX) begin
			return FORCE_W'(32'h7FFF_FFFF);
		end else if (v < SMIN) begin
			return FORCE_W'(32'h8000_0000);
		end
		return FORCE_W'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (t_valid && en) begin
			ax_q   <= sx;
			ay_q   <= sy;
			az_q   <= sz;
			aovf_q <= sovf;
		end
	end

	logic load;

	assign load = t_valid && en && t_tag.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fx       <= clamp(sx);
			fy       <= clamp(sy);
			fz       <= clamp(sz);
			overflow <= sovf || (sx > SMAX) || (sx < SMIN) || (sy > SMAX) || (sy < SMIN)
			            || (sz > SMAX) || (sz < SMIN);
		end
	end

endmodule

// ===== src/picf_term.sv =====
module picf_term import picf_pkg::*; #(
	parameter int MAX_REACH       = DEF_MAX_REACH,
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
	localparam int XW             = COORD_FRAC_BITS + 4 + $clog2(MAX_REACH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  term_tag_t                 in_tag,
	input  logic signed [XW-1:0]      in_x,
	input  logic signed [XW-1:0]      in_y,
	input  logic signed [XW-1:0]      in_z,
	output logic                      out_valid,
	output term_tag_t                 out_tag,
	output logic signed [FORCE_W-1:0] out_fx,
	output logic signed [FORCE_W-1:0] out_fy,
	output logic signed [FORCE_W-1:0] out_fz,
	output logic                      out_ovf
);

	localparam int SW   = 2 * XW;
	localparam int MW   = XW;
	localparam int DW   = SW + MW;
	localparam int QB   = QUOT_BITS;
	localparam int NSH  = 2 * COORD_FRAC_BITS + 16;
	localparam int NA   = XW + NSH;
	localparam int NB   = DW + QB;
	localparam int NW   = ((NA > NB) ? NA : NB) + 1;

	typedef struct packed {
		logic      valid;
		term_tag_t tag;
		logic      zero;
		logic [2:0] neg;
	} ctl_t;

	// s1: squares and magnitudes
	ctl_t             ctl_s1;
	logic [SW-1:0]    sq_s1 [3];
	logic [XW-1:0]    mag_s1 [3];
	logic signed [XW-1:0] cin [3];

	assign cin[0] = in_x;
	assign cin[1] = in_y;
	assign cin[2] = in_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.tag   <= in_tag;
			ctl_s1.zero  <= (in_x == '0) && (in_y == '0) && (in_z == '0);
			ctl_s1.neg   <= {in_z[XW-1], in_y[XW-1], in_x[XW-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				mag_s1[l]     <= cin[l][XW-1] ? XW'(-cin[l]) : XW'(cin[l]);
				sq_s1[l]      <= SW'(cin[l] * cin[l]);
			end
		end
	end

	// s2: sum of squares, start of the root chain
	ctl_t          rt_ctl [MW+1];
	logic [SW-1:0] rt_s   [MW+1];
	logic [SW-1:0] rt_rem [MW+1];
	logic [SW-1:0] rt_res [MW+1];
	logic [XW-1:0] rt_mag [MW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_ctl[0] <= '0;
		end else if (en) begin
			rt_ctl[0] <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0]        <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			rt_rem[0]      <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			rt_res[0]      <= '0;
			rt_mag[0]      <= mag_s1;
		end
	end

	// integer square root, one result bit per stage
	for (genvar t = 0; t < MW; t++) begin : g_rt
		localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << (SW - 2 - 2 * t);
		logic [SW-1:0] trial;
		logic [SW-1:0] rem_n;
		logic [SW-1:0] res_n;

		always_comb begin
			trial = rt_res[t] + BIT;
			if (rt_rem[t] >= trial) begin
				rem_n = rt_rem[t] - trial;
				res_n = (rt_res[t] >> 1) + BIT;
			end else begin
				rem_n = rt_rem[t];
				res_n = rt_res[t] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_ctl[t+1] <= '0;
			end else if (en) begin
				rt_ctl[t+1] <= rt_ctl[t];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[t+1]        <= rt_s[t];
				rt_rem[t+1]      <= rem_n;
				rt_res[t+1]      <= res_n;
				rt_mag[t+1]      <= rt_mag[t];
			end
		end
	end

	// denominator S * m as two half-width partial products
	ctl_t          ctl_m1;
	logic [2*XW-1:0] plo_m1;
	logic [2*XW-1:0] phi_m1;
	logic [XW-1:0] mag_m1 [3];
	logic [MW-1:0] root;

	assign root = rt_res[MW][MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_m1 <= '0;
		end else if (en) begin
			ctl_m1 <= rt_ctl[MW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_m1      <= rt_s[MW][XW-1:0] * root;
			phi_m1      <= rt_s[MW][SW-1:XW] * root;
			mag_m1      <= rt_mag[MW];
		end
	end

	ctl_t          ctl_m2;
	logic [DW-1:0] den_m2;
	logic [XW-1:0] mag_m2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_m2 <= '0;
		end else if (en) begin
			ctl_m2 <= ctl_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// zero distance: any nonzero divisor, the term is dropped later
			if (ctl_m1.zero) begin
				den_m2 <= DW'(1);
			end else begin
				den_m2 <= (DW'(phi_m1) << XW) + DW'(plo_m1);
			end
			mag_m2 <= mag_m1;
		end
	end

	// rounded numerators and the coarse overflow test
	ctl_t          dv_ctl [QB+1];
	logic [DW-1:0] dv_d   [QB+1];
	logic [NW-1:0] dv_r   [QB+1][3];
	logic [QB-1:0] dv_q   [QB+1][3];
	logic [2:0]    dv_ovf [QB+1];
	logic [NW-1:0] num [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num[l] = (NW'(mag_m2[l]) << NSH) + NW'(den_m2 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_ctl[0] <= '0;
		end else if (en) begin
			dv_ctl[0] <= ctl_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d[0]        <= den_m2;
			for (int l = 0; l < 3; l++) begin
				dv_r[0][l]   <= num[l];
				dv_q[0][l]   <= '0;
				dv_ovf[0][l] <= num[l] >= (NW'(den_m2) << QB);
			end
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar t = 0; t < QB; t++) begin : g_dv
		localparam int B = QB - 1 - t;
		logic [NW-1:0] sub;
		logic [NW-1:0] r_n [3];
		logic [QB-1:0] q_n [3];

		always_comb begin
			sub = NW'(dv_d[t]) << B;
			for (int l = 0; l < 3; l++) begin
				r_n[l] = dv_r[t][l];
				q_n[l] = dv_q[t][l];
				if (dv_r[t][l] >= sub) begin
					r_n[l]    = dv_r[t][l] - sub;
					q_n[l][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_ctl[t+1] <= '0;
			end else if (en) begin
				dv_ctl[t+1] <= dv_ctl[t];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_d[t+1]        <= dv_d[t];
				dv_r[t+1]        <= r_n;
				dv_q[t+1]        <= q_n;
				dv_ovf[t+1]      <= dv_ovf[t];
			end
		end
	end

	// sign and saturation
	localparam logic [QB-1:0] POS_MAX = QB'(32'h7FFF_FFFF);
	localparam logic [QB-1:0] NEG_MAX = QB'(32'h8000_0000);

	logic signed [FORCE_W-1:0] tv [3];
	logic [2:0]                sat;
	ctl_t                      fc;

	assign fc = dv_ctl[QB];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (fc.tag.null_term || fc.zero) begin
				tv[l]  = '0;
				sat[l] = 1'b0;
			end else if (!fc.neg[l]) begin
				sat[l] = dv_ovf[QB][l] || (dv_q[QB][l] > POS_MAX);
				tv[l]  = sat[l] ? FORCE_W'(32'h7FFF_FFFF) : FORCE_W'(dv_q[QB][l]);
			end else begin
				sat[l] = dv_ovf[QB][l] || (dv_q[QB][l] > NEG_MAX);
				tv[l]  = sat[l] ? FORCE_W'(32'h8000_0000) : FORCE_W'(-dv_q[QB][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= fc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_tag <= fc.tag;
			out_fx  <= tv[0];
			out_fy  <= tv[1];
			out_fz  <= tv[2];
			out_ovf <= (|sat) || (fc.zero && !fc.tag.null_term);
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import picf_pkg::*;

	localparam int  FRAC        = DEF_COORD_FRAC_BITS;
	localparam int  CW          = FRAC + 4;
	localparam int  REACH_LIMIT = DEF_MAX_REACH;
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  DRAIN_WAIT  = 200;
	localparam logic [REACH_W-1:0] REACH_OVER = 5'd31;

	typedef struct {
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
		logic                 func;
	} disp_t;

	typedef struct {
		logic signed [FORCE_W-1:0] fx;
		logic signed [FORCE_W-1:0] fy;
		logic signed [FORCE_W-1:0] fz;
		logic                      ovf;
	} force_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [REACH_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CW-1:0] dx = '0, dy = '0, dz = '0;
	logic func = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [FORCE_W-1:0] fx, fy, fz;
	logic overflow;

	periodic_image_coulomb_force uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.dx(dx), .dy(dy), .dz(dz), .func(func),
		.out_valid(out_valid), .out_stall(out_stall),
		.fx(fx), .fy(fy), .fz(fz), .overflow(overflow)
	);

	disp_t  pending_disps[$];
	force_t expected_forces[$];
	int     reach_reg = 16;
	int     gap_max = 12;
	int     stall_max = 12;
	int     gap_cnt = 0;
	int     stall_cnt = 0;
	int     mismatches = 0;
	longint cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned root64(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// one component of one image, rounded half away from zero, saturated
	function automatic longint image_term(longint c, logic [127:0] den, inout logic ovf);
		logic [127:0] num, q;
		longint unsigned mag;
		if (c == 0) return 0;
		mag = (c < 0) ? -c : c;
		num = ({64'd0, mag} << (2 * FRAC + 16)) + (den >> 1);
		q = num / den;
		if (c > 0) begin
			if (q > 128'h7FFF_FFFF) begin
				ovf = 1;
				return 64'sd2147483647;
			end
			return longint'(q[63:0]);
		end
		if (q > 128'h8000_0000) begin
			ovf = 1;
			return -64'sd2147483648;
		end
		return -longint'(q[63:0]);
	endfunction

	function automatic logic signed [FORCE_W-1:0] clamp_force(longint v, inout logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1;
			return 32'sh8000_0000;
		end
		return v[FORCE_W-1:0];
	endfunction

	function automatic force_t image_field_sum(disp_t d, int reach);
		force_t r;
		longint x0, y0, z, x, y, ax, ay, az, one;
		longint unsigned s, m;
		logic [127:0] den;
		logic ovf;
		int k;
		k = (reach > REACH_LIMIT) ? REACH_LIMIT : reach;
		one = 64'sd1 << FRAC;
		x0 = d.dx;
		y0 = d.dy;
		z = d.dz;
		ax = 0; ay = 0; az = 0;
		ovf = 0;
		for (int j = -k; j <= k; j++) begin
			for (int i = -k; i <= k; i++) begin
				if (!(d.func && i == 0 && j == 0)) begin
					x = x0 + i * one;
					y = y0 + j * one;
					s = x * x + y * y + z * z;
					if (s == 0) begin
						ovf = 1;
					end else begin
						m = root64(s);
						den = {64'd0, s} * {64'd0, m};
						ax += image_term(x, den, ovf);
						ay += image_term(y, den, ovf);
						az += image_term(z, den, ovf);
					end
				end
			end
		end
		r.fx = clamp_force(ax, ovf);
		r.fy = clamp_force(ay, ovf);
		r.fz = clamp_force(az, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		logic signed [CW-1:0] v;
		case ($urandom_range(0, 4)) inside
			0, 1: v = CW'($urandom);
			// near a lattice point, so some image lands close to or on zero
			2: v = CW'(($signed($urandom_range(0, 14)) - 7) * (1 << FRAC)
				+ $signed($urandom_range(0, 6)) - 3);
			3: v = CW'($signed($urandom_range(0, 2000)) - 1000);
			default: v = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
		endcase
		return v;
	endfunction

	function automatic disp_t rand_disp();
		disp_t d;
		d.dx = rand_coord();
		d.dy = rand_coord();
		d.dz = ($urandom_range(0, 3) == 0) ? '0 : rand_coord();
		d.func = 1'($urandom_range(0, 1));
		return d;
	endfunction

	task automatic push_disp(int x, int y, int z, logic f);
		disp_t d;
		d.dx = CW'(x);
		d.dy = CW'(y);
		d.dz = CW'(z);
		d.func = f;
		pending_disps = {pending_disps, d};
	endtask

	// checked on the falling edge, after the driver's updates have settled
	task automatic wait_idle();
		while (pending_disps.size() != 0 || in_valid || expected_forces.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reach(logic [REACH_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		reach_reg = v;
	endtask

	task automatic random_phase(logic [REACH_W-1:0] v, int n, int gmax, int smax);
		wait_idle();
		write_reach(v);
		gap_max = gmax;
		stall_max = smax;
		repeat (n) pending_disps = {pending_disps, rand_disp()};
	endtask

	// request driver
	always @(posedge clk) begin
		disp_t d;
		if (in_valid && !in_stall) begin
			expected_forces = {expected_forces,
				image_field_sum(disp_t'{dx, dy, dz, func}, reach_reg)};
			gap_cnt = $urandom_range(0, gap_max);
		end
		if (!in_valid || !in_stall) begin
			if (gap_cnt > 0) begin
				gap_cnt--;
				in_valid <= 0;
			end else if (pending_disps.size() != 0) begin
				d = pending_disps.pop_front();
				dx <= d.dx;
				dy <= d.dy;
				dz <= d.dz;
				func <= d.func;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		force_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("Mismatches found");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (expected_forces.size() == 0) begin
				$display("%0t unexpected result fx=%h fy=%h fz=%h ovf=%b",
					$time, fx, fy, fz, overflow);
				mismatches++;
			end else begin
				e = expected_forces.pop_front();
				if (fx !== e.fx) begin
					$display("%0t fx expected %h actual %h", $time, e.fx, fx);
					mismatches++;
				end
				if (fy !== e.fy) begin
					$display("%0t fy expected %h actual %h", $time, e.fy, fy);
					mismatches++;
				end
				if (fz !== e.fz) begin
					$display("%0t fz expected %h actual %h", $time, e.fz, fz);
					mismatches++;
				end
				if (overflow !== e.ovf) begin
					$display("%0t overflow expected %b actual %b", $time, e.ovf, overflow);
					mismatches++;
				end
			end
			stall_cnt = $urandom_range(0, stall_max);
		end
		if (stall_cnt > 0) begin
			stall_cnt--;
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// reset reach of 16: extremes, self term, zero distance
		push_disp(0, 0, 0, 0);
		push_disp(0, 0, 0, 1);
		push_disp(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0);
		push_disp(-524288, -524288, -524288, 1);
		push_disp(-524288, 524287, 0, 0);
		push_disp(1 << FRAC, 0, 0, 0);
		push_disp(1, 0, 0, 1);
		push_disp(0, -1, 0, 1);
		push_disp(0, 0, 1, 0);
		push_disp(12345, -54321, 777, 1);

		// no images around the centre: empty sum and a single term
		wait_idle();
		write_reach(0);
		push_disp(0, 0, 0, 1);
		push_disp(0, 0, 0, 0);
		push_disp(1, 1, 1, 0);
		push_disp(-1, 0, 0, 0);
		push_disp(524287, -524288, 524287, 0);
		push_disp(-524288, -524288, -524288, 0);
		push_disp(777, 888, 0, 1);

		// one image away lands on zero distance
		wait_idle();
		write_reach(1);
		push_disp(1 << FRAC, 0, 0, 1);
		push_disp(-(1 << FRAC), 1 << FRAC, 0, 0);
		push_disp(1, 1, 0, 0);
		push_disp(1, 0, 0, 0);

		random_phase(5'd1, 150, 12, 12);
		random_phase(5'd2, 140, 0, 0);
		random_phase(5'd0, 70, 12, 12);
		random_phase(5'd3, 90, 12, 0);
		random_phase(5'd4, 50, 0, 12);
		random_phase(REACH_OVER, 8, 12, 12);
		random_phase(5'd16, 6, 5, 5);
		random_phase(5'd17, 4, 12, 12);
		random_phase(5'd2, 30, 12, 12);

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_forces.size() != 0) begin
			$display("%0t %0d results never arrived", $time, expected_forces.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/picf_pkg.sv
src/picf_term.sv
src/periodic_image_coulomb_force.sv
tb/sv/tb.sv
